[hw/rtl/esl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_pkg
// Shared sizes, constants and request codes for the event slot table.
// ----------------------------------------------------------------------------
package esl_pkg;

  // Table geometry
  localparam int SLOT_COUNT   = 32;
  localparam int IDX_W        = $clog2(SLOT_COUNT);
  localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
  localparam int HANDLE_IDX_W = 16;

  // Slot RAM word: {class, handler}
  localparam int WORD_W = 32;
  localparam int RAM_W  = 2 * WORD_W;

  // Answer constants
  localparam logic [WORD_W-1:0] HANDLE_TAG     = 32'hF100_0000;
  localparam logic [WORD_W-1:0] FULL_ANSWER    = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] IMMEDIATE_MODE = 32'h0000_1000;
  localparam logic [WORD_W-1:0] ANSWER_ONE     = 32'h0000_0001;

  // Request codes
  typedef enum logic [2:0] {
    KIND_OPEN    = 3'd0,
    KIND_CLOSE   = 3'd1,
    KIND_TEST    = 3'd2,
    KIND_ENABLE  = 3'd3,
    KIND_DISABLE = 3'd4,
    KIND_DELIVER = 3'd5
  } kind_t;

endpackage

[hw/rtl/esl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module esl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/event_slot_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_slot_table
// Table of event slots: open, close, test, enable, disable and deliver requests.
// Deliver walks used slots through the slot RAM one per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel  | ports                                    | direction
//  ---------+------------------------------------------+----------
//  in_      | valid/ready, kind, class, spec, mode,    | input
//           | handler_address, handle                  |
//  out_     | valid/ready, return_value, is_callback,  | output
//           | callback_target, callback_argument, last |
//
//  Open/close/test/enable/disable: accept, then execute.
//  Deliver: accept, a scan that steps the single RAM read port through the
//  used slots one slot per cycle while no callback waits, then a final result.
//  Reset (rst_n low, synchronous) empties the table; no clearing pass.
//  The result register frees the input side: a result can wait while the
//  next request is taken, and a full result register stalls the sequencer.
// ----------------------------------------------------------------------------
module event_slot_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_event_class,
  input  logic [31:0] in_event_spec,
  input  logic [31:0] in_event_mode,
  input  logic [31:0] in_handler_address,
  input  logic [31:0] in_event_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_return_value,
  output logic        out_is_callback,
  output logic [31:0] out_callback_target,
  output logic [31:0] out_callback_argument,
  output logic        out_last
);

  localparam int SC = esl_pkg::SLOT_COUNT;
  localparam int IW = esl_pkg::IDX_W;
  localparam int CW = esl_pkg::CNT_W;
  localparam int HW = esl_pkg::HANDLE_IDX_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_t;

  // Control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] chk_idx_r, chk_idx_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Request and payload registers
  logic [2:0]  kind_r, kind_nxt;
  logic [31:0] class_r, class_nxt;
  logic [31:0] spec_r, spec_nxt;
  logic [31:0] mode_r, mode_nxt;
  logic [31:0] handler_r, handler_nxt;
  logic [31:0] handle_r, handle_nxt;
  logic [31:0] out_rv_r, out_rv_nxt;
  logic        out_cb_r, out_cb_nxt;
  logic [31:0] out_tgt_r, out_tgt_nxt;
  logic [31:0] out_arg_r, out_arg_nxt;
  logic        out_last_r, out_last_nxt;

  // Slot flags
  logic [SC-1:0] imm_r, imm_nxt;
  logic [SC-1:0] open_r, open_nxt;
  logic [SC-1:0] en_r, en_nxt;
  logic [SC-1:0] done_r, done_nxt;

  // Slot RAM
  logic                        ram_wr_en;
  logic [IW-1:0]               ram_wr_addr;
  logic [esl_pkg::RAM_W-1:0]   ram_wr_data;
  logic [IW-1:0]               ram_rd_addr;
  logic [esl_pkg::RAM_W-1:0]   ram_rd_data;

  esl_ram #(
    .WIDTH(esl_pkg::RAM_W),
    .DEPTH(SC)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Handle decode
  logic [HW-1:0] h_idx;
  logic          h_valid;
  logic [IW-1:0] h_slot;
  assign h_idx   = handle_r[HW-1:0];
  assign h_valid = h_idx < HW'(count_r);
  assign h_slot  = h_idx[IW-1:0];

  // Scan compare on the slot under check
  logic [IW-1:0] c_slot;
  logic [31:0]   rd_class, rd_handler;
  logic [CW-1:0] chk_inc;
  logic          scan_end, match, cb_hit, out_free;
  assign c_slot     = chk_idx_r[IW-1:0];
  assign rd_class   = ram_rd_data[esl_pkg::RAM_W-1:esl_pkg::WORD_W];
  assign rd_handler = ram_rd_data[esl_pkg::WORD_W-1:0];
  assign chk_inc    = chk_idx_r + CW'(1);
  assign scan_end   = chk_idx_r == count_r;
  assign match      = open_r[c_slot] & en_r[c_slot] & (rd_class == class_r);
  assign cb_hit     = match & imm_r[c_slot] & (rd_handler != '0);
  assign out_free   = !out_valid_r || out_ready;

  assign in_ready = state_r == ST_IDLE;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    chk_idx_nxt   = chk_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    class_nxt     = class_r;
    spec_nxt      = spec_r;
    mode_nxt      = mode_r;
    handler_nxt   = handler_r;
    handle_nxt    = handle_r;
    out_rv_nxt    = out_rv_r;
    out_cb_nxt    = out_cb_r;
    out_tgt_nxt   = out_tgt_r;
    out_arg_nxt   = out_arg_r;
    out_last_nxt  = out_last_r;
    imm_nxt       = imm_r;
    open_nxt      = open_r;
    en_nxt        = en_r;
    done_nxt      = done_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = count_r[IW-1:0];
    ram_wr_data   = {class_r, handler_r};
    ram_rd_addr   = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          class_nxt   = in_event_class;
          spec_nxt    = in_event_spec;
          mode_nxt    = in_event_mode;
          handler_nxt = in_handler_address;
          handle_nxt  = in_event_handle;
          chk_idx_nxt = '0;
          if (in_kind == esl_pkg::KIND_DELIVER) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cb_nxt    = 1'b0;
          out_tgt_nxt   = '0;
          out_arg_nxt   = '0;
          out_last_nxt  = 1'b1;
          out_rv_nxt    = '0;
          state_nxt     = ST_IDLE;
          case (esl_pkg::kind_t'(kind_r))
            esl_pkg::KIND_OPEN: begin
              if (count_r == CW'(SC)) begin
                out_rv_nxt = esl_pkg::FULL_ANSWER;
              end else begin
                ram_wr_en               = 1'b1;
                imm_nxt[count_r[IW-1:0]]  = mode_r == esl_pkg::IMMEDIATE_MODE;
                open_nxt[count_r[IW-1:0]] = 1'b1;
                en_nxt[count_r[IW-1:0]]   = 1'b0;
                done_nxt[count_r[IW-1:0]] = 1'b0;
                out_rv_nxt = esl_pkg::HANDLE_TAG | 32'(count_r);
                count_nxt  = count_r + CW'(1);
              end
            end
            esl_pkg::KIND_CLOSE: begin
              if (h_valid) open_nxt[h_slot] = 1'b0;
              out_rv_nxt = esl_pkg::ANSWER_ONE;
            end
            esl_pkg::KIND_TEST: begin
              if (h_valid && done_r[h_slot]) begin
                done_nxt[h_slot] = 1'b0;
                out_rv_nxt       = esl_pkg::ANSWER_ONE;
              end
            end
            esl_pkg::KIND_ENABLE: begin
              if (h_valid) en_nxt[h_slot] = 1'b1;
              out_rv_nxt = esl_pkg::ANSWER_ONE;
            end
            esl_pkg::KIND_DISABLE: begin
              if (h_valid) en_nxt[h_slot] = 1'b0;
              out_rv_nxt = esl_pkg::ANSWER_ONE;
            end
            default: begin
              out_rv_nxt = '0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Hold the read address while a callback waits for the result register
        ram_rd_addr = c_slot;
        if (scan_end) begin
          state_nxt = ST_FIN;
        end else if (cb_hit) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_rv_nxt    = '0;
            out_cb_nxt    = 1'b1;
            out_tgt_nxt   = rd_handler;
            out_arg_nxt   = spec_r;
            out_last_nxt  = 1'b0;
            chk_idx_nxt   = chk_inc;
            ram_rd_addr   = chk_inc[IW-1:0];
          end
        end else begin
          if (match) done_nxt[c_slot] = 1'b1;
          chk_idx_nxt = chk_inc;
          ram_rd_addr = chk_inc[IW-1:0];
        end
      end

      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = '0;
          out_cb_nxt    = 1'b0;
          out_tgt_nxt   = '0;
          out_arg_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, registered outputs and slot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      chk_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_idx_r   <= chk_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    class_r    <= class_nxt;
    spec_r     <= spec_nxt;
    mode_r     <= mode_nxt;
    handler_r  <= handler_nxt;
    handle_r   <= handle_nxt;
    out_rv_r   <= out_rv_nxt;
    out_cb_r   <= out_cb_nxt;
    out_tgt_r  <= out_tgt_nxt;
    out_arg_r  <= out_arg_nxt;
    out_last_r <= out_last_nxt;
    imm_r      <= imm_nxt;
    open_r     <= open_nxt;
    en_r       <= en_nxt;
    done_r     <= done_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_return_value      = out_rv_r;
  assign out_is_callback       = out_cb_r;
  assign out_callback_target   = out_tgt_r;
  assign out_callback_argument = out_arg_r;
  assign out_last              = out_last_r;

endmodule

[hw/rtl/esl_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_chk
// Port-level checks for the event slot table, bound to the top level.
// ----------------------------------------------------------------------------
module esl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_return_value,
  input logic        out_is_callback,
  input logic [31:0] out_callback_target,
  input logic [31:0] out_callback_argument,
  input logic        out_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_return_value)
      && $stable(out_is_callback) && $stable(out_last))
    else $error("stalled result changed");

  // One request at a time: an input transfer closes the input side
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // A callback is never the final result and answers zero
  a_cb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_callback |-> !out_last && out_return_value == '0)
    else $error("callback result marked last or nonzero answer");

  // Non-callback results carry cleared callback fields and are final
  a_plain_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_callback |->
      out_last && out_callback_target == '0 && out_callback_argument == '0)
    else $error("plain result with callback fields or not last");

endmodule

bind event_slot_table esl_chk u_esl_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_return_value     (out_return_value),
  .out_is_callback      (out_is_callback),
  .out_callback_target  (out_callback_target),
  .out_callback_argument(out_callback_argument),
  .out_last             (out_last)
);

[tb/event_slot_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_slot_table_checker
// Watches both channels of the event slot table, keeps its own copy of the
// slot table, predicts the results of every accepted request and compares
// each result transfer, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module event_slot_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_event_class,
  input  logic [31:0] in_event_spec,
  input  logic [31:0] in_event_mode,
  input  logic [31:0] in_handler_address,
  input  logic [31:0] in_event_handle,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_return_value,
  input  logic        out_is_callback,
  input  logic [31:0] out_callback_target,
  input  logic [31:0] out_callback_argument,
  input  logic        out_last,
  output int          fail_count,
  output int          outstanding,
  output int          callbacks_seen
);

  typedef struct packed {
    logic [31:0] return_value;
    logic        is_callback;
    logic [31:0] callback_target;
    logic [31:0] callback_argument;
    logic        last;
  } slot_result_t;

  // Expected results, oldest first
  slot_result_t expected_results[$];
  slot_result_t head_result;

  // Shadow slot table
  int          slots_used;
  logic [31:0] tbl_class     [esl_pkg::SLOT_COUNT];
  logic [31:0] tbl_handler   [esl_pkg::SLOT_COUNT];
  logic        tbl_immediate [esl_pkg::SLOT_COUNT];
  logic        tbl_open      [esl_pkg::SLOT_COUNT];
  logic        tbl_enabled   [esl_pkg::SLOT_COUNT];
  logic        tbl_done      [esl_pkg::SLOT_COUNT];

  // Plain single answer: no callback, ends the request
  function automatic slot_result_t plain_answer(logic [31:0] value);
    slot_result_t r;
    r.return_value      = value;
    r.is_callback       = 1'b0;
    r.callback_target   = '0;
    r.callback_argument = '0;
    r.last              = 1'b1;
    return r;
  endfunction

  // Update the shadow table for one request and queue what it must produce
  task automatic predict_request(input logic [2:0] kind, input logic [31:0] cls,
                                 input logic [31:0] spec, input logic [31:0] mode,
                                 input logic [31:0] handler, input logic [31:0] handle);
    int           idx;
    logic         hit;
    logic [31:0]  answer;
    slot_result_t cb;
    idx    = int'(handle[esl_pkg::HANDLE_IDX_W-1:0]);
    hit    = (idx < slots_used);
    answer = '0;
    case (kind)
      esl_pkg::KIND_OPEN: begin
        if (slots_used >= esl_pkg::SLOT_COUNT) begin
          answer = esl_pkg::FULL_ANSWER;
        end else begin
          tbl_class[slots_used]     = cls;
          tbl_handler[slots_used]   = handler;
          tbl_immediate[slots_used] = (mode == esl_pkg::IMMEDIATE_MODE);
          tbl_open[slots_used]      = 1'b1;
          tbl_enabled[slots_used]   = 1'b0;
          tbl_done[slots_used]      = 1'b0;
          answer = esl_pkg::HANDLE_TAG | 32'(slots_used);
          slots_used++;
        end
      end
      esl_pkg::KIND_CLOSE: begin
        if (hit) tbl_open[idx] = 1'b0;
        answer = esl_pkg::ANSWER_ONE;
      end
      esl_pkg::KIND_TEST: begin
        if (hit && tbl_done[idx]) begin
          tbl_done[idx] = 1'b0;
          answer = esl_pkg::ANSWER_ONE;
        end
      end
      esl_pkg::KIND_ENABLE: begin
        if (hit) tbl_enabled[idx] = 1'b1;
        answer = esl_pkg::ANSWER_ONE;
      end
      esl_pkg::KIND_DISABLE: begin
        if (hit) tbl_enabled[idx] = 1'b0;
        answer = esl_pkg::ANSWER_ONE;
      end
      esl_pkg::KIND_DELIVER: begin
        // Lowest slot first; immediate slots with a handler call back,
        // other matching slots only get marked done
        for (int i = 0; i < slots_used; i++) begin
          if (tbl_open[i] && tbl_enabled[i] && tbl_class[i] == cls) begin
            if (tbl_immediate[i] && tbl_handler[i] != '0) begin
              cb                   = plain_answer('0);
              cb.is_callback       = 1'b1;
              cb.callback_target   = tbl_handler[i];
              cb.callback_argument = spec;
              cb.last              = 1'b0;
              expected_results.push_back(cb);
            end else begin
              tbl_done[i] = 1'b1;
            end
          end
        end
      end
      default: answer = '0;
    endcase
    expected_results.push_back(plain_answer(answer));
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result side is checked before the request side: a request accepted at
  // this edge cannot have produced a result yet
  always @(posedge clk) begin
    if (!rst_n) begin
      slots_used = 0;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual rv %h cb %b last %b",
                   $time, out_return_value, out_is_callback, out_last);
          fail_count++;
        end else begin
          head_result = expected_results.pop_front();
          check_field("return_value", head_result.return_value, out_return_value);
          check_field("is_callback", 32'(head_result.is_callback), 32'(out_is_callback));
          check_field("callback_target", head_result.callback_target,
                      out_callback_target);
          check_field("callback_argument", head_result.callback_argument,
                      out_callback_argument);
          check_field("last", 32'(head_result.last), 32'(out_last));
          if (head_result.is_callback) callbacks_seen++;
        end
      end
      if (in_valid && in_ready) begin
        predict_request(in_kind, in_event_class, in_event_spec, in_event_mode,
                        in_handler_address, in_event_handle);
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

[tb/event_slot_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_slot_table_tb
// Drives open/close/test/enable/disable/deliver requests into the event slot
// table: a directed opening, then random requests over four flow-control
// phases. Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module event_slot_table_tb;

  // Codes outside the request set
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int PHASE_ITEMS  = 39;
  localparam int DRAIN_CYCLES = 40;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind            = '0;
  logic [31:0] in_event_class     = '0;
  logic [31:0] in_event_spec      = '0;
  logic [31:0] in_event_mode      = '0;
  logic [31:0] in_handler_address = '0;
  logic [31:0] in_event_handle    = '0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [31:0] out_return_value;
  logic        out_is_callback;
  logic [31:0] out_callback_target;
  logic [31:0] out_callback_argument;
  logic        out_last;

  int fail_count;
  int outstanding;
  int callbacks_seen;

  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          opened       = 0;
  int          sent_per_kind [8];
  logic [31:0] class_pool    [4];

  event_slot_table dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_event_class        (in_event_class),
    .in_event_spec         (in_event_spec),
    .in_event_mode         (in_event_mode),
    .in_handler_address    (in_handler_address),
    .in_event_handle       (in_event_handle),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_return_value      (out_return_value),
    .out_is_callback       (out_is_callback),
    .out_callback_target   (out_callback_target),
    .out_callback_argument (out_callback_argument),
    .out_last              (out_last)
  );

  event_slot_table_checker checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_kind               (in_kind),
    .in_event_class        (in_event_class),
    .in_event_spec         (in_event_spec),
    .in_event_mode         (in_event_mode),
    .in_handler_address    (in_handler_address),
    .in_event_handle       (in_event_handle),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_return_value      (out_return_value),
    .out_is_callback       (out_is_callback),
    .out_callback_target   (out_callback_target),
    .out_callback_argument (out_callback_argument),
    .out_last              (out_last),
    .fail_count            (fail_count),
    .outstanding           (outstanding),
    .callbacks_seen        (callbacks_seen)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("event_slot_table_tb failed");
    $finish;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // One request transfer, with random idle cycles ahead of it
  task automatic send_request(input logic [2:0] kind, input logic [31:0] cls,
                              input logic [31:0] spec, input logic [31:0] mode,
                              input logic [31:0] handler, input logic [31:0] handle);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_kind            <= kind;
    in_event_class     <= cls;
    in_event_spec      <= spec;
    in_event_mode      <= mode;
    in_handler_address <= handler;
    in_event_handle    <= handle;
    do @(posedge clk); while (!in_ready);
    sent_per_kind[kind]++;
    if (kind == esl_pkg::KIND_OPEN && opened < esl_pkg::SLOT_COUNT) opened++;
  endtask

  // Hold the sender off until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Few classes so that delivers find many matching slots
  function automatic logic [31:0] pick_class();
    if ($urandom_range(9) == 0) return $urandom;
    return class_pool[$urandom_range(3)];
  endfunction

  // Mostly handles of used slots with random upper bits, some out of range
  function automatic logic [31:0] pick_handle();
    logic [31:0] h;
    h = $urandom;
    if (opened > 0 && $urandom_range(99) < 85)
      h[15:0] = 16'($urandom_range(opened - 1));
    else if ($urandom_range(1) == 1)
      h[15:0] = 16'(opened + $urandom_range(3));
    return h;
  endfunction

  task automatic random_request();
    int          r;
    logic [31:0] mode;
    r = $urandom_range(99);
    if (r < 24) begin
      mode = ($urandom_range(99) < 60) ? esl_pkg::IMMEDIATE_MODE : $urandom;
      if ($urandom_range(9) == 0)
        mode = esl_pkg::IMMEDIATE_MODE ^ (32'h1 << $urandom_range(31));
      send_request(esl_pkg::KIND_OPEN, pick_class(), $urandom, mode,
                   ($urandom_range(99) < 85) ? $urandom : 32'h0, $urandom);
    end else if (r < 44) begin
      send_request(esl_pkg::KIND_ENABLE, $urandom, $urandom, $urandom, $urandom,
                   pick_handle());
    end else if (r < 64) begin
      send_request(esl_pkg::KIND_DELIVER, pick_class(), $urandom, $urandom, $urandom,
                   $urandom);
    end else if (r < 78) begin
      send_request(esl_pkg::KIND_TEST, $urandom, $urandom, $urandom, $urandom,
                   pick_handle());
    end else if (r < 86) begin
      send_request(esl_pkg::KIND_DISABLE, $urandom, $urandom, $urandom, $urandom,
                   pick_handle());
    end else if (r < 93) begin
      send_request(esl_pkg::KIND_CLOSE, $urandom, $urandom, $urandom, $urandom,
                   pick_handle());
    end else begin
      send_request(($urandom_range(1) == 1) ? KIND_SPARE_HI : KIND_SPARE_LO,
                   $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) class_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, spare codes, then a small populated table
    send_request(esl_pkg::KIND_TEST,    '0, '0, '0, '0, 32'h0000_0000);
    send_request(esl_pkg::KIND_CLOSE,   '0, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(esl_pkg::KIND_ENABLE,  '0, '0, '0, '0, 32'h0000_0000);
    send_request(esl_pkg::KIND_DISABLE, '0, '0, '0, '0, 32'h0000_0000);
    send_request(esl_pkg::KIND_DELIVER, '0, 32'hFFFF_FFFF, '0, '0, '0);
    send_request(KIND_SPARE_LO, '1, '1, '1, '1, '1);
    send_request(KIND_SPARE_HI, '0, '0, '0, '0, '0);
    // immediate with handler, immediate without handler, near-immediate mode
    send_request(esl_pkg::KIND_OPEN, 32'h0, '0, esl_pkg::IMMEDIATE_MODE, 32'hFFFF_FFFF, '0);
    send_request(esl_pkg::KIND_OPEN, 32'h0, '0, esl_pkg::IMMEDIATE_MODE, 32'h0, '0);
    send_request(esl_pkg::KIND_OPEN, 32'h0, '0, esl_pkg::IMMEDIATE_MODE | 32'h1,
                 32'h0000_1234, '0);
    send_request(esl_pkg::KIND_OPEN, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 32'h0, '0);
    // nothing enabled yet
    send_request(esl_pkg::KIND_DELIVER, 32'h0, 32'h1234_5678, '0, '0, '0);
    // upper handle bits are ignored
    send_request(esl_pkg::KIND_ENABLE, '0, '0, '0, '0, 32'hFFFF_0000);
    send_request(esl_pkg::KIND_ENABLE, '0, '0, '0, '0, 32'h0000_0001);
    send_request(esl_pkg::KIND_ENABLE, '0, '0, '0, '0, 32'h0000_0002);
    send_request(esl_pkg::KIND_ENABLE, '0, '0, '0, '0, 32'h0000_0003);
    send_request(esl_pkg::KIND_DELIVER, 32'h0, 32'hFFFF_FFFF, '0, '0, '0);
    // done mark is cleared by the first test
    send_request(esl_pkg::KIND_TEST, '0, '0, '0, '0, 32'h0000_0001);
    send_request(esl_pkg::KIND_TEST, '0, '0, '0, '0, 32'h0000_0001);
    send_request(esl_pkg::KIND_TEST, '0, '0, '0, '0, 32'hABCD_0002);
    // index equal to the used slot count selects nothing
    send_request(esl_pkg::KIND_TEST, '0, '0, '0, '0, 32'h0000_0004);
    send_request(esl_pkg::KIND_DISABLE, '0, '0, '0, '0, 32'h0000_0000);
    send_request(esl_pkg::KIND_CLOSE, '0, '0, '0, '0, 32'h0000_0002);
    send_request(esl_pkg::KIND_DELIVER, 32'h0, 32'h0, '0, '0, '0);
    send_request(esl_pkg::KIND_DELIVER, 32'hFFFF_FFFF, 32'h0F0F_F0F0, '0, '0, '0);

    // Random phases: free flow, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: open %0d, close %0d, test %0d, enable %0d, disable %0d, deliver %0d",
             sent_per_kind[esl_pkg::KIND_OPEN], sent_per_kind[esl_pkg::KIND_CLOSE],
             sent_per_kind[esl_pkg::KIND_TEST], sent_per_kind[esl_pkg::KIND_ENABLE],
             sent_per_kind[esl_pkg::KIND_DISABLE], sent_per_kind[esl_pkg::KIND_DELIVER]);
    $display("spare codes %0d, slots filled %0d of %0d, callbacks checked %0d",
             sent_per_kind[KIND_SPARE_LO] + sent_per_kind[KIND_SPARE_HI], opened,
             esl_pkg::SLOT_COUNT, callbacks_seen);
    if (fail_count == 0) begin
      $display("event_slot_table_tb passed");
    end else begin
      $display("event_slot_table_tb failed");
    end
    $finish;
  end

endmodule
